[rtl/core/rob_pkg.sv]
// ----------------------------------------------------------------------------
// Reorder buffer package
// Shared constants, operation and status codes, controller command types.
// ----------------------------------------------------------------------------
package rob_pkg;

    localparam int DEPTH = 32;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int TAG_W = 5;
    localparam int ID_W  = 32;

    localparam logic [2:0] KIND_INSERT = 3'd0;
    localparam logic [2:0] KIND_EXEC   = 3'd1;
    localparam logic [2:0] KIND_READY  = 3'd2;
    localparam logic [2:0] KIND_WAKEUP = 3'd3;
    localparam logic [2:0] KIND_REMOVE = 3'd4;
    localparam logic [2:0] KIND_QUERY  = 3'd5;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_NOHEAD = 2'd2;

    typedef struct packed {
        logic       load;
        logic       execute;
        logic       report;
    } rob_cmd_t;

endpackage

[rtl/core/rob_ctrl.sv]
// ----------------------------------------------------------------------------
// Reorder buffer controller
// Sequence each word through load, execute and report.
// ----------------------------------------------------------------------------
module rob_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output rob_pkg::rob_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_REP  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_EXEC;
            S_EXEC:  state_next = S_REP;
            S_REP:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign cmd.load    = (state_reg == S_IDLE) && start;
    assign cmd.execute = (state_reg == S_EXEC);
    assign cmd.report  = (state_reg == S_REP);

    a_exec_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.execute) else $error("execute did not follow load");
    a_report_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> cmd.report) else $error("report did not follow execute");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.execute, cmd.report})) else $error("overlapping commands");

endmodule

[rtl/core/rob_dp.sv]
// ----------------------------------------------------------------------------
// Reorder buffer datapath
// Entry storage, pointers, associative match and result registers.
// ----------------------------------------------------------------------------
module rob_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rob_pkg::rob_cmd_t             cmd,
    input  logic [2:0]                    kind,
    input  logic [rob_pkg::ID_W-1:0]      inst_id,
    input  logic [rob_pkg::TAG_W-1:0]     src1_wait_tag,
    input  logic                          src1_is_ready,
    input  logic [rob_pkg::TAG_W-1:0]     src2_wait_tag,
    input  logic                          src2_is_ready,
    input  logic [rob_pkg::TAG_W-1:0]     query_tag,
    output logic                          done,
    output logic [1:0]                    status,
    output logic [4:0]                    slot,
    output logic                          tag_ready,
    output logic                          space_free,
    output logic                          head_ready,
    output logic [rob_pkg::ID_W-1:0]      out_inst_id,
    output logic [rob_pkg::TAG_W-1:0]     out_src1_tag,
    output logic                          out_src1_ready,
    output logic [rob_pkg::TAG_W-1:0]     out_src2_tag,
    output logic                          out_src2_ready
);

    localparam int N  = rob_pkg::DEPTH;
    localparam int IW = rob_pkg::IDX_W;

    logic [N-1:0] valid_reg;
    logic [N-1:0] done_reg;
    logic [N-1:0] issued_reg;
    logic [rob_pkg::ID_W-1:0]  id_mem   [N];
    logic [rob_pkg::TAG_W-1:0] t1_mem   [N];
    logic [N-1:0]              r1_reg;
    logic [rob_pkg::TAG_W-1:0] t2_mem   [N];
    logic [N-1:0]              r2_reg;
    logic [IW-1:0] head_reg;
    logic [IW-1:0] tail_reg;

    logic [2:0]                kind_reg;
    logic [rob_pkg::ID_W-1:0]  id_reg;
    logic [rob_pkg::TAG_W-1:0] it1_reg;
    logic                      ir1_reg;
    logic [rob_pkg::TAG_W-1:0] it2_reg;
    logic                      ir2_reg;
    logic [rob_pkg::TAG_W-1:0] qt_reg;

    logic [N-1:0] match_reg;
    logic [N-1:0] match_next;
    logic         found;
    logic [IW-1:0] hit;
    logic         qt_in;
    logic [IW-1:0] qidx;

    logic [1:0]               status_reg;
    logic [4:0]               slot_reg;
    logic                     tag_ready_reg;
    logic [rob_pkg::ID_W-1:0] oid_reg;
    logic [rob_pkg::TAG_W-1:0] ot1_reg;
    logic                     or1_reg;
    logic [rob_pkg::TAG_W-1:0] ot2_reg;
    logic                     or2_reg;
    logic                     done_out_reg;

    always_comb
    begin
        for (int i = 0; i < N; i++)
            match_next[i] = valid_reg[i] && (id_mem[i] == inst_id);
    end

    always_comb
    begin
        found = 1'b0;
        hit   = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                found = 1'b1;
                hit   = IW'(i);
            end
        end
    end

    assign qt_in = (32'(qt_reg) < 32'(N));
    assign qidx  = IW'(qt_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind;
            id_reg    <= inst_id;
            it1_reg   <= src1_wait_tag;
            ir1_reg   <= src1_is_ready;
            it2_reg   <= src2_wait_tag;
            ir2_reg   <= src2_is_ready;
            qt_reg    <= query_tag;
            match_reg <= match_next;
        end
        if (cmd.execute && kind_reg == rob_pkg::KIND_INSERT && !valid_reg[tail_reg])
        begin
            id_mem[tail_reg] <= id_reg;
            t1_mem[tail_reg] <= it1_reg;
            t2_mem[tail_reg] <= it2_reg;
        end
        if (cmd.execute)
        begin
            status_reg    <= rob_pkg::ST_DONE;
            slot_reg      <= '0;
            tag_ready_reg <= 1'b0;
            oid_reg       <= '0;
            ot1_reg       <= '0;
            or1_reg       <= 1'b0;
            ot2_reg       <= '0;
            or2_reg       <= 1'b0;
            unique case (kind_reg)
                rob_pkg::KIND_INSERT:
                    if (valid_reg[tail_reg])
                        status_reg <= rob_pkg::ST_FULL;
                    else
                        slot_reg <= 5'(tail_reg);
                rob_pkg::KIND_REMOVE:
                    if (!(valid_reg[head_reg] && done_reg[head_reg]))
                        status_reg <= rob_pkg::ST_NOHEAD;
                    else
                    begin
                        oid_reg <= id_mem[head_reg];
                        ot1_reg <= t1_mem[head_reg];
                        or1_reg <= r1_reg[head_reg];
                        ot2_reg <= t2_mem[head_reg];
                        or2_reg <= r2_reg[head_reg];
                    end
                rob_pkg::KIND_QUERY:
                    tag_ready_reg <= qt_in && valid_reg[qidx] && done_reg[qidx];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            done_reg     <= '0;
            issued_reg   <= '0;
            r1_reg       <= '0;
            r2_reg       <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            done_out_reg <= 1'b0;
        end
        else
        begin
            done_out_reg <= cmd.execute;
            if (cmd.execute)
            begin
                unique case (kind_reg)
                    rob_pkg::KIND_INSERT:
                        if (!valid_reg[tail_reg])
                        begin
                            valid_reg[tail_reg]  <= 1'b1;
                            done_reg[tail_reg]   <= 1'b0;
                            issued_reg[tail_reg] <= 1'b0;
                            r1_reg[tail_reg]     <= ir1_reg;
                            r2_reg[tail_reg]     <= ir2_reg;
                            tail_reg <= (32'(tail_reg) == N - 1) ? '0 : tail_reg + 1'b1;
                        end
                    rob_pkg::KIND_EXEC:
                        if (found)
                            issued_reg[hit] <= r1_reg[hit] && r2_reg[hit];
                    rob_pkg::KIND_READY:
                        if (found)
                            done_reg[hit] <= 1'b1;
                    rob_pkg::KIND_WAKEUP:
                        for (int i = 0; i < N; i++)
                        begin
                            if (valid_reg[i] && t1_mem[i] == qt_reg)
                                r1_reg[i] <= 1'b1;
                            if (valid_reg[i] && t2_mem[i] == qt_reg)
                                r2_reg[i] <= 1'b1;
                        end
                    rob_pkg::KIND_REMOVE:
                        if (valid_reg[head_reg] && done_reg[head_reg])
                        begin
                            valid_reg[head_reg] <= 1'b0;
                            head_reg <= (32'(head_reg) == N - 1) ? '0 : head_reg + 1'b1;
                        end
                    default: ;
                endcase
            end
        end
    end

    assign done           = done_out_reg;
    assign status         = status_reg;
    assign slot           = slot_reg;
    assign tag_ready      = tag_ready_reg;
    assign space_free     = !valid_reg[tail_reg];
    assign head_ready     = valid_reg[head_reg] && done_reg[head_reg];
    assign out_inst_id    = oid_reg;
    assign out_src1_tag   = ot1_reg;
    assign out_src1_ready = or1_reg;
    assign out_src2_tag   = ot2_reg;
    assign out_src2_ready = or2_reg;

    a_insert_tail: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute && kind_reg == rob_pkg::KIND_INSERT && !valid_reg[tail_reg]
        |=> valid_reg[$past(tail_reg)]) else $error("insert lost");
    a_remove_head: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute && kind_reg == rob_pkg::KIND_REMOVE && head_ready
        |=> !valid_reg[$past(head_reg)]) else $error("remove lost");
    a_ptr_still: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.execute |=> $stable(head_reg) && $stable(tail_reg))
        else $error("pointer moved while idle");

endmodule

[rtl/core/reorder_buffer_core.sv]
// ----------------------------------------------------------------------------
// Reorder buffer core
// Circular reorder buffer of rob_pkg::DEPTH entries with associative match.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with the word's fields while busy is low; the word is taken
//   at that edge and busy rises for the following cycles.
//   The load step registers the word and the instruction-number match
//   vector, the execute step updates the entry flags and pointers, and the
//   report step shows the result with strobe high for exactly one cycle.
//   strobe rises once the word has passed the execute state and the done
//   register; a new word is taken only when the controller is back in idle
//   after the report step, never while busy is high.
//   space_free and head_ready on the result reflect state after the word.
//   Reset clears all entry flags and both pointers; entry payload is left
//   as is and is only read from valid entries.
//   The receiver cannot stall: sample the result when strobe is high.
// ----------------------------------------------------------------------------
module reorder_buffer_core
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [2:0]                kind,
    input  logic [rob_pkg::ID_W-1:0]  inst_id,
    input  logic [rob_pkg::TAG_W-1:0] src1_wait_tag,
    input  logic                      src1_is_ready,
    input  logic [rob_pkg::TAG_W-1:0] src2_wait_tag,
    input  logic                      src2_is_ready,
    input  logic [rob_pkg::TAG_W-1:0] query_tag,
    output logic                      strobe,
    output logic [1:0]                status,
    output logic [4:0]                slot,
    output logic                      tag_ready,
    output logic                      space_free,
    output logic                      head_ready,
    output logic [rob_pkg::ID_W-1:0]  out_inst_id,
    output logic [rob_pkg::TAG_W-1:0] out_src1_tag,
    output logic                      out_src1_ready,
    output logic [rob_pkg::TAG_W-1:0] out_src2_tag,
    output logic                      out_src2_ready
);

    rob_pkg::rob_cmd_t cmd;

    rob_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    rob_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .kind           (kind),
        .inst_id        (inst_id),
        .src1_wait_tag  (src1_wait_tag),
        .src1_is_ready  (src1_is_ready),
        .src2_wait_tag  (src2_wait_tag),
        .src2_is_ready  (src2_is_ready),
        .query_tag      (query_tag),
        .done           (strobe),
        .status         (status),
        .slot           (slot),
        .tag_ready      (tag_ready),
        .space_free     (space_free),
        .head_ready     (head_ready),
        .out_inst_id    (out_inst_id),
        .out_src1_tag   (out_src1_tag),
        .out_src1_ready (out_src1_ready),
        .out_src2_tag   (out_src2_tag),
        .out_src2_ready (out_src2_ready)
    );

endmodule
